// ----- src/ael_pkg.sv -----
`default_nettype none
package ael_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int ACC_EXT_W = VALUE_WIDTH + 4;
	localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

	localparam int TOKEN_VALUE_W = 32;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] ASCII_PLUS = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_STAR = 8'h2A;
	localparam logic [7:0] ASCII_SLASH = 8'h2F;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] DIGIT_LO_CHAR = 8'h30;
	localparam logic [7:0] DIGIT_HI_CHAR = 8'h39;
	localparam logic [7:0] NUL_CHAR = 8'h00;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_SPACE,
		CLS_PLUS,
		CLS_MINUS,
		CLS_MUL,
		CLS_DIV,
		CLS_OTHER,
		CLS_EOT
	} cls_t;

	typedef enum logic [2:0] {
		KIND_INT   = 3'd0,
		KIND_PLUS  = 3'd1,
		KIND_MINUS = 3'd2,
		KIND_MUL   = 3'd3,
		KIND_DIV   = 3'd4,
		KIND_EOF   = 3'd5,
		KIND_ERR   = 3'd6
	} kind_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
	} q_item_t;

	typedef struct packed {
		kind_t                    kind;
		logic [TOKEN_VALUE_W-1:0] value;
		logic                     ovf;
		logic                     last;
	} tok_t;

endpackage
`default_nettype wire

// ----- src/ael_front.sv -----
`default_nettype none
module ael_front import ael_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_TDATA_W-1:0] s_tdata,
	input  wire logic                  s_tuser,
	output logic                       q_valid,
	output q_item_t                    q_item,
	input  wire logic                  q_pop
);

	q_item_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	q_item_t            new_item;
	logic               push;
	logic               pop;

	// zero byte terminates the text just like the end marker
	always_comb begin
		new_item.digit = s_tdata[3:0];
		if (s_tuser || s_tdata == NUL_CHAR) begin
			new_item.cls = CLS_EOT;
		end else begin
			case (s_tdata) inside
				[DIGIT_LO_CHAR:DIGIT_HI_CHAR]: new_item.cls = CLS_DIGIT;
				ASCII_SPACE:                   new_item.cls = CLS_SPACE;
				ASCII_PLUS:                    new_item.cls = CLS_PLUS;
				ASCII_MINUS:                   new_item.cls = CLS_MINUS;
				ASCII_STAR:                    new_item.cls = CLS_MUL;
				ASCII_SLASH:                   new_item.cls = CLS_DIV;
				default:                       new_item.cls = CLS_OTHER;
			endcase
		end
	end

	assign s_tready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign push = s_tvalid && s_tready;
	assign q_valid = count_q != '0;
	assign pop = q_pop && q_valid;
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= new_item;
	end

endmodule
`default_nettype wire

// ----- src/ael_back.sv -----
`default_nettype none
module ael_back import ael_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_valid,
	input  wire q_item_t q_item,
	output logic         q_pop,
	output logic         out_valid,
	output tok_t         out_tok,
	input  wire logic    out_ready
);

	logic                   in_num_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic                   sat_q;
	logic                   halted_q;

	logic                   out_valid_q;
	tok_t                   out_q;
	logic                   pend_valid_q;
	tok_t                   pend_q;

	tok_t                   tok0;
	tok_t                   tok1;
	tok_t                   int_tok;
	tok_t                   op_tok;
	logic [1:0]             tok_n;
	logic                   clear_num;
	logic                   set_halt;
	logic [ACC_EXT_W-1:0]   acc_next;
	logic                   acc_over;
	logic                   can_adv;

	function automatic kind_t op_kind(cls_t c);
		case (c)
			CLS_PLUS:  return KIND_PLUS;
			CLS_MINUS: return KIND_MINUS;
			CLS_MUL:   return KIND_MUL;
			CLS_DIV:   return KIND_DIV;
			CLS_EOT:   return KIND_EOF;
			default:   return KIND_ERR;
		endcase
	endfunction

	// acc*10 + digit as shift-add
	assign acc_next = (ACC_EXT_W'(acc_q) << 3) + (ACC_EXT_W'(acc_q) << 1)
		+ ACC_EXT_W'(q_item.digit);
	assign acc_over = acc_next > ACC_EXT_W'(VALUE_MAX);

	always_comb begin
		int_tok.kind = KIND_INT;
		int_tok.value = TOKEN_VALUE_W'(acc_q);
		int_tok.ovf = sat_q;
		int_tok.last = 1'b0;
		op_tok.kind = op_kind(q_item.cls);
		op_tok.value = '0;
		op_tok.ovf = 1'b0;
		op_tok.last = 1'b1;

		tok0 = op_tok;
		tok1 = op_tok;
		tok_n = 2'd0;
		clear_num = 1'b0;
		set_halt = 1'b0;

		if (q_item.cls == CLS_EOT) begin
			clear_num = 1'b1;
			if (!halted_q) begin
				if (in_num_q) begin
					tok0 = int_tok;
					tok_n = 2'd2;
				end else begin
					tok_n = 2'd1;
				end
			end
		end else if (!halted_q && q_item.cls != CLS_DIGIT) begin
			clear_num = 1'b1;
			if (q_item.cls == CLS_SPACE) begin
				tok0 = int_tok;
				tok0.last = 1'b1;
				tok_n = in_num_q ? 2'd1 : 2'd0;
			end else begin
				set_halt = q_item.cls == CLS_OTHER;
				if (in_num_q) begin
					tok0 = int_tok;
					tok_n = 2'd2;
				end else begin
					tok_n = 2'd1;
				end
			end
		end
	end

	assign can_adv = !out_valid_q || out_ready;
	assign q_pop = q_valid && !pend_valid_q && (can_adv || tok_n == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_num_q <= 1'b0;
			acc_q <= '0;
			sat_q <= 1'b0;
			halted_q <= 1'b0;
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.cls == CLS_EOT) begin
					halted_q <= 1'b0;
				end else if (set_halt) begin
					halted_q <= 1'b1;
				end
				if (clear_num) begin
					in_num_q <= 1'b0;
					acc_q <= '0;
					sat_q <= 1'b0;
				end else if (!halted_q && q_item.cls == CLS_DIGIT) begin
					in_num_q <= 1'b1;
					if (!in_num_q) begin
						acc_q <= VALUE_WIDTH'(q_item.digit);
						sat_q <= 1'b0;
					end else if (acc_over) begin
						acc_q <= VALUE_MAX;
						sat_q <= 1'b1;
					end else begin
						acc_q <= acc_next[VALUE_WIDTH-1:0];
					end
				end
			end
			if (can_adv) begin
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
					pend_valid_q <= 1'b0;
				end else if (q_pop && tok_n != 2'd0) begin
					out_valid_q <= 1'b1;
					pend_valid_q <= tok_n == 2'd2;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_adv) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (q_pop && tok_n != 2'd0) begin
				out_q <= tok0;
				pend_q <= tok1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_tok = out_q;

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("second token held without a first");

	a_idle_number_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_num_q |-> (acc_q == '0 && !sat_q))
		else $error("number state left over outside a digit run");

	a_halt_no_number: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !in_num_q)
		else $error("digit run open after error");

	a_non_int_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.kind != KIND_INT) |-> (out_q.value == '0 && !out_q.ovf))
		else $error("operator token carries a value");

	a_ovf_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.ovf) |-> out_q.value == TOKEN_VALUE_W'(VALUE_MAX))
		else $error("saturated token below maximum");

endmodule
`default_nettype wire

// ----- src/arithmetic_expression_tokenizer.sv -----
// channel | dir | tdata (low bit up)                     | tuser           | tlast
// s_*     | in  | char_code[7:0]                         | end_of_text     | -
// m_*     | out | token_value[31:0] overflowed[32] pad   | token_kind[2:0] | last_of_run
//
// Input takes one byte word per cycle while the queue has room; a byte that
// closes a digit run and gives its own token sends two tokens on the single port.
// A four-word queue sits between classifier and executor, so a back-end stall
// or a two-token byte does not stop input until the queue is full.
// Output is registered: s_tready does not depend on m_tready.
// Reset is asynchronous and clears all control state at once; queue and output data are not reset.
`default_nettype none
module arithmetic_expression_tokenizer import ael_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // char_code
	input  wire logic                   s_tuser,  // end_of_text
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // token_value, overflowed, pad
	output logic [OUT_TUSER_W-1:0]      m_tuser,  // token_kind
	output logic                        m_tlast
);

	logic    q_valid;
	q_item_t q_item;
	logic    q_pop;
	tok_t    out_tok;

	ael_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ael_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_tok   (out_tok),
		.out_ready (m_tready)
	);

	assign m_tdata = {7'b0000000, out_tok.ovf, out_tok.value};
	assign m_tuser = out_tok.kind;
	assign m_tlast = out_tok.last;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none
module tb_top import ael_pkg::*;;

	localparam int IDLE_LIMIT = 1000;
	localparam int TARGET_WORDS = 1600;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
		bit         drain;   // hold this word back until all tokens are out
	} in_word_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic        ovf;
		logic        last;
	} token_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_tvalid = 1'b0;
	wire logic              s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // char_code
	logic                   s_tuser = 1'b0; // end_of_text
	wire logic              m_tvalid;
	logic                   m_tready = 1'b0;
	wire logic [OUT_TDATA_W-1:0] m_tdata;   // token_value, overflowed, pad
	wire logic [OUT_TUSER_W-1:0] m_tuser;   // token_kind
	wire logic              m_tlast;

	in_word_t byte_q[$];
	token_t   token_q[$];

	int mismatches = 0;
	int words_total = 0;
	int words_taken = 0;
	int idle_cycles = 0;

	// predictor state
	bit          num_open;
	logic [63:0] num_acc;
	bit          num_sat;
	bit          lex_halted;

	// generator state
	bit gen_halted = 0;
	int live_words = 0;

	arithmetic_expression_tokenizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic bit is_digit(input logic [7:0] ch);
		return ch >= DIGIT_LO_CHAR && ch <= DIGIT_HI_CHAR;
	endfunction

	function automatic bit is_op(input logic [7:0] ch);
		return ch == ASCII_PLUS || ch == ASCII_MINUS || ch == ASCII_STAR || ch == ASCII_SLASH;
	endfunction

	// Works out the tokens one accepted word gives and queues them.
	task automatic lex_step(input logic [7:0] ch, input logic eot);
		token_t      tok[2];
		int          n;
		logic [63:0] d;
		logic [63:0] vmax;
		n = 0;
		vmax = 64'(VALUE_MAX);
		d = 64'(ch - DIGIT_LO_CHAR);
		if (eot || ch == NUL_CHAR) begin
			if (!lex_halted) begin
				if (num_open) begin
					tok[n] = '{KIND_INT, num_acc[31:0], num_sat, 1'b0};
					n++;
				end
				tok[n] = '{KIND_EOF, 32'd0, 1'b0, 1'b0};
				n++;
			end
			num_open = 0;
			num_acc = '0;
			num_sat = 0;
			lex_halted = 0;
		end else if (!lex_halted) begin
			if (is_digit(ch)) begin
				if (!num_open) begin
					num_open = 1;
					num_acc = d;
					num_sat = 0;
				end else if (num_acc > (vmax - d) / 10) begin
					num_acc = vmax;
					num_sat = 1;
				end else begin
					num_acc = num_acc * 10 + d;
				end
			end else begin
				if (num_open) begin
					tok[n] = '{KIND_INT, num_acc[31:0], num_sat, 1'b0};
					n++;
				end
				num_open = 0;
				num_acc = '0;
				num_sat = 0;
				if (ch != ASCII_SPACE) begin
					case (ch)
						ASCII_PLUS:  tok[n] = '{KIND_PLUS, 32'd0, 1'b0, 1'b0};
						ASCII_MINUS: tok[n] = '{KIND_MINUS, 32'd0, 1'b0, 1'b0};
						ASCII_STAR:  tok[n] = '{KIND_MUL, 32'd0, 1'b0, 1'b0};
						ASCII_SLASH: tok[n] = '{KIND_DIV, 32'd0, 1'b0, 1'b0};
						default: begin
							tok[n] = '{KIND_ERR, 32'd0, 1'b0, 1'b0};
							lex_halted = 1;
						end
					endcase
					n++;
				end
			end
		end
		if (n > 0)
			tok[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			token_q = {token_q, tok[i]};
	endtask

	task automatic push_word(input logic [7:0] ch, input logic eot, input bit drain);
		in_word_t w;
		if (!gen_halted)
			live_words++;
		w.ch = ch;
		w.eot = eot;
		w.drain = drain;
		byte_q = {byte_q, w};
		if (eot || ch == NUL_CHAR)
			gen_halted = 0;
		else if (!is_digit(ch) && !is_op(ch) && ch != ASCII_SPACE)
			gen_halted = 1;
	endtask

	task automatic push_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			push_word(txt[i], 1'b0, 1'b0);
	endtask

	task automatic push_random_text();
		int n_elem;
		int pick;
		int len;
		n_elem = $urandom_range(1, 8);
		for (int e = 0; e < n_elem; e++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(9, 12);
				for (int i = 0; i < len; i++)
					push_word(DIGIT_LO_CHAR + 8'($urandom_range(0, 9)), 1'b0,
						e == 0 && i == 0 && $urandom_range(0, 19) == 0);
			end else if (pick < 77) begin
				case ($urandom_range(0, 3))
					0: push_word(ASCII_PLUS, 1'b0, 1'b0);
					1: push_word(ASCII_MINUS, 1'b0, 1'b0);
					2: push_word(ASCII_STAR, 1'b0, 1'b0);
					default: push_word(ASCII_SLASH, 1'b0, 1'b0);
				endcase
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 2))
					push_word(ASCII_SPACE, 1'b0, 1'b0);
			end else if (pick < 98) begin
				push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end else begin
				push_word(NUL_CHAR, 1'b0, 1'b0);
			end
		end
		// end of text usually by the marker, with junk in the byte lane
		if ($urandom_range(0, 4) == 0)
			push_word(NUL_CHAR, 1'b0, 1'b0);
		else
			push_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
	endtask

	// sender
	int s_wait = 0;
	int s_run = 0;
	always @(posedge clk or negedge arst_n) begin : drive_words
		in_word_t w;
		int gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			s_wait = 0;
			s_run = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				lex_step(s_tdata, s_tuser);
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (s_wait != 0) begin
					s_tvalid <= 1'b0;
					s_wait--;
				end else if (byte_q.size() != 0 &&
						!(byte_q[0].drain && token_q.size() != 0)) begin
					w = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= w.ch;
					s_tuser <= w.eot;
					if (s_run > 0) begin
						s_run--;
						gap = 0;
					end else begin
						gap = $urandom_range(0, 10);
						if ($urandom_range(0, 15) == 0)
							s_run = $urandom_range(20, 60);
					end
					s_wait = gap;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	int r_wait = 0;
	int r_run = 0;
	always @(posedge clk or negedge arst_n) begin : check_tokens
		token_t got;
		token_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			r_wait = 0;
			r_run = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = '{kind_t'(m_tuser), m_tdata[31:0], m_tdata[32], m_tlast};
				if (token_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected token: kind %0d value %h ovf %b last %b",
							got.kind, got.value, got.ovf, got.last);
					mismatches++;
				end else begin
					want = token_q.pop_front();
					if (got != want) begin
						if (mismatches < 10)
							$display("token mismatch: exp kind %0d value %h ovf %b last %b, ",
								want.kind, want.value, want.ovf, want.last,
								"got kind %0d value %h ovf %b last %b",
								got.kind, got.value, got.ovf, got.last);
						mismatches++;
					end
				end
				if (r_run > 0) begin
					r_run--;
					r_wait = 0;
				end else begin
					r_wait = $urandom_range(0, 10);
					if ($urandom_range(0, 15) == 0)
						r_run = $urandom_range(20, 60);
				end
			end else if (r_wait > 0) begin
				r_wait--;
			end
			m_tready <= (r_wait == 0);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		num_open = 0;
		num_acc = '0;
		num_sat = 0;
		lex_halted = 0;

		// largest value that fits, closed by an operator
		push_text("4294967295/");
		push_text("-+*");
		// one past the top saturates; a zero byte ends the text
		push_text("4294967296");
		push_word(NUL_CHAR, 1'b0, 1'b0);
		// error token, then bytes ignored and no end-of-file token
		push_word(8'hFF, 1'b0, 1'b1);
		push_word(8'h33, 1'b0, 1'b0);
		push_word(8'h41, 1'b1, 1'b0);

		while (live_words < TARGET_WORDS)
			push_random_text();
		words_total = byte_q.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_taken < words_total)
			@(negedge clk);
		while (token_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (mismatches == 0 && token_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
src/ael_pkg.sv
src/ael_front.sv
src/ael_back.sv
src/arithmetic_expression_tokenizer.sv
tb/sv/tb_top.sv
